>>> rtl/mne_pkg.sv
`default_nettype none
package mne_pkg;

  // Number of neighbor items averaged into one mean.
  localparam int NEIGHBORS = 6;
  localparam int NB_LIMIT  = (NEIGHBORS < 1) ? 1 : NEIGHBORS;

  localparam int N_IN    = 6;
  localparam int N_LANE  = 8;
  localparam int LANE_W  = 3;
  localparam int ROW_W   = 4;
  localparam int N_ROW   = 16;
  localparam int DATA_W  = 16;
  localparam int PROD_W  = 32;
  localparam int CNT_W   = 6;

  // Table rows: w0 rows 0..5, b0 row 6, w1 rows 7..14, b1 row 15.
  localparam logic [ROW_W-1:0] ROW_B0 = 4'd6;
  localparam logic [ROW_W-1:0] ROW_W1 = 4'd7;
  localparam logic [ROW_W-1:0] ROW_B1 = 4'd15;

  // A bias enters the sum as b * 256 (Q3.12 to Q.20).
  localparam logic signed [DATA_W-1:0] BIAS_GAIN = 16'sd256;

  localparam int ACC0_W = 36;
  localparam int SUM_W  = 40;

  // The mean is ((|sum| + MEAN_DIV / 2) >> 12) / NB_LIMIT. The division by
  // NB_LIMIT is a multiply by a rounded-up reciprocal, exact for shifted
  // values below SAT_LIM; anything at or above SAT_LIM saturates.
  localparam int MEAN_DIV = NB_LIMIT * 4096;
  localparam int SHR_W    = SUM_W + 1 - 12;
  localparam int QIN_W    = 20;
  localparam int RCP_SH   = 26;
  localparam int RCP_W    = 27;
  localparam int SAT_LIM  = 32768 * NB_LIMIT;
  localparam logic [RCP_W-1:0] RCP = RCP_W'((2 ** RCP_SH + NB_LIMIT - 1) / NB_LIMIT);

  localparam logic FUNC_COEF     = 1'b0;
  localparam logic FUNC_NEIGHBOR = 1'b1;

  typedef struct packed {
    logic                     wr_en;
    logic [ROW_W-1:0]         wr_row;
    logic [LANE_W-1:0]        wr_lane;
    logic signed [DATA_W-1:0] wr_data;
    logic                     mac;
    logic                     dst_sum;
    logic                     rot;
    logic [ROW_W-1:0]         row;
    logic [LANE_W-1:0]        step;
    logic                     use_chain;
    logic signed [DATA_W-1:0] bcast;
    logic                     hload;
    logic                     shift;
    logic                     div_start;
    logic                     div_step;
    logic                     clr;
  } ctl_t;

endpackage
`default_nettype wire

>>> rtl/mne_in_if.sv
`default_nettype none
interface mne_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [6:0]  coef_addr;
  logic signed [15:0] coef_value;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_z;

  modport source (output valid, func, coef_addr, coef_value, pos_x, pos_y, pos_z,
                  vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, func, coef_addr, coef_value, pos_x, pos_y, pos_z,
                vel_x, vel_y, vel_z, output ready);
endinterface
`default_nettype wire

>>> rtl/mne_out_if.sv
`default_nettype none
interface mne_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] mean_0;
  logic signed [15:0] mean_1;
  logic signed [15:0] mean_2;
  logic signed [15:0] mean_3;
  logic signed [15:0] mean_4;
  logic signed [15:0] mean_5;
  logic signed [15:0] mean_6;
  logic signed [15:0] mean_7;

  modport source (output valid, mean_0, mean_1, mean_2, mean_3, mean_4, mean_5,
                  mean_6, mean_7, input ready);
  modport sink (input valid, mean_0, mean_1, mean_2, mean_3, mean_4, mean_5,
                mean_6, mean_7, output ready);
endinterface
`default_nettype wire

>>> rtl/mne_cell.sv
`default_nettype none
// One output lane: its column of the coefficient table, a multiply-accumulate
// pipeline, the hidden value passed along the ring, and the mean scaling.
module mne_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [mne_pkg::LANE_W-1:0]    lane_id,
  input  wire mne_pkg::ctl_t                 ctl,
  input  wire logic signed [mne_pkg::DATA_W-1:0] h_in,
  output logic signed [mne_pkg::DATA_W-1:0]  h_out,
  output logic signed [mne_pkg::DATA_W-1:0]  mean
);

  localparam logic [mne_pkg::SUM_W:0] DIV_HALF =
    (mne_pkg::SUM_W + 1)'(mne_pkg::MEAN_DIV / 2);
  localparam logic [mne_pkg::SHR_W-1:0] SAT_VAL = mne_pkg::SHR_W'(mne_pkg::SAT_LIM);
  localparam int SH_W = mne_pkg::ACC0_W + 1 - 12;

  logic signed [mne_pkg::DATA_W-1:0] mem [mne_pkg::N_ROW];
  logic [mne_pkg::N_ROW-1:0]         vld;
  logic [mne_pkg::LANE_W-1:0]        rot_idx;
  logic [mne_pkg::ROW_W-1:0]         row_sel;

  logic signed [mne_pkg::DATA_W-1:0] a_w;
  logic                              a_vld;
  logic signed [mne_pkg::DATA_W-1:0] a_x;
  logic                              a_mac;
  logic                              a_dst;
  logic signed [mne_pkg::DATA_W-1:0] w_eff;

  logic signed [mne_pkg::PROD_W-1:0] p;
  logic                              p_mac;
  logic                              p_dst;

  logic signed [mne_pkg::ACC0_W-1:0] acc0;
  logic signed [mne_pkg::SUM_W-1:0]  sum;
  logic signed [mne_pkg::DATA_W-1:0] h;

  logic signed [mne_pkg::ACC0_W:0]   rnd;
  logic [SH_W-1:0]                   sh;
  logic signed [mne_pkg::DATA_W-1:0] h_next;

  logic [mne_pkg::SUM_W-1:0]                  mag;
  logic [mne_pkg::SUM_W:0]                    mag_rnd;
  logic [mne_pkg::SHR_W-1:0]                  tq;
  logic [mne_pkg::QIN_W+mne_pkg::RCP_W-1:0]   prod;
  logic [mne_pkg::DATA_W-2:0]                 q;
  logic                                       neg;
  logic                                       sat;

  assign rot_idx = lane_id + ctl.step;
  assign row_sel = ctl.rot ? (mne_pkg::ROW_W1 + {1'b0, rot_idx}) : ctl.row;

  always_ff @(posedge clk) begin
    if (ctl.wr_en && ctl.wr_lane == lane_id) begin
      mem[ctl.wr_row] <= ctl.wr_data;
    end
    a_w <= mem[row_sel];
    a_x <= ctl.use_chain ? h : ctl.bcast;
    p   <= w_eff * a_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      a_vld <= 1'b0;
      a_mac <= 1'b0;
      a_dst <= 1'b0;
      p_mac <= 1'b0;
      p_dst <= 1'b0;
    end else begin
      if (ctl.wr_en && ctl.wr_lane == lane_id) begin
        vld[ctl.wr_row] <= 1'b1;
      end
      a_vld <= vld[row_sel];
      a_mac <= ctl.mac;
      a_dst <= ctl.dst_sum;
      p_mac <= a_mac;
      p_dst <= a_dst;
    end
  end

  // Words never written read as zero.
  assign w_eff = a_vld ? a_w : '0;

  // Round the layer-0 sum from Q.20 to Q7.8 and saturate.
  assign rnd = (mne_pkg::ACC0_W + 1)'(acc0) + (mne_pkg::ACC0_W + 1)'(2048);
  assign sh  = rnd[mne_pkg::ACC0_W:12];

  always_comb begin
    if (&sh[SH_W-1:15] || ~|sh[SH_W-1:15]) begin
      h_next = sh[15:0];
    end else if (sh[SH_W-1]) begin
      h_next = 16'sh8000;
    end else begin
      h_next = 16'sh7FFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc0 <= '0;
      sum  <= '0;
    end else begin
      if (p_mac && !p_dst) begin
        acc0 <= acc0 + mne_pkg::ACC0_W'(p);
      end else if (ctl.hload) begin
        acc0 <= '0;
      end
      if (p_mac && p_dst) begin
        sum <= sum + mne_pkg::SUM_W'(p);
      end else if (ctl.clr) begin
        sum <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hload) begin
      h <= h_next;
    end else if (ctl.shift) begin
      h <= h_in;
    end
  end

  assign h_out = h;

  // Mean: the rounded magnitude is shifted down by 12 and registered, then
  // divided by the neighbor count through a reciprocal multiply.
  assign mag     = sum[mne_pkg::SUM_W-1] ? mne_pkg::SUM_W'(-sum) : mne_pkg::SUM_W'(sum);
  assign mag_rnd = {1'b0, mag} + DIV_HALF;
  assign prod    = tq[mne_pkg::QIN_W-1:0] * mne_pkg::RCP;

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      neg <= sum[mne_pkg::SUM_W-1];
      tq  <= mag_rnd[mne_pkg::SUM_W:12];
    end else if (ctl.div_step) begin
      sat <= (tq >= SAT_VAL);
      q   <= prod[mne_pkg::RCP_SH +: (mne_pkg::DATA_W - 1)];
    end
  end

  always_comb begin
    if (sat) begin
      mean = neg ? 16'sh8000 : 16'sh7FFF;
    end else if (neg) begin
      mean = -{1'b0, q};
    end else begin
      mean = {1'b0, q};
    end
  end

endmodule
`default_nettype wire

>>> rtl/mne_seq.sv
`default_nettype none
// Sequencer: takes input items, holds the observation, and steps the lanes
// through both layers, the mean division and the hand-off to the output.
module mne_seq (
  input  wire logic    clk,
  input  wire logic    rst,
  mne_in_if.sink       item_in,
  input  wire logic    out_busy,
  output mne_pkg::ctl_t ctl,
  output logic         out_load
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_L0   = 4'd1;
  localparam logic [3:0] S_D0   = 4'd2;
  localparam logic [3:0] S_HL   = 4'd3;
  localparam logic [3:0] S_L1   = 4'd4;
  localparam logic [3:0] S_D1   = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  localparam logic [mne_pkg::CNT_W-1:0] NB_LAST = mne_pkg::CNT_W'(mne_pkg::NB_LIMIT - 1);
  localparam logic [mne_pkg::CNT_W-1:0] L0_LAST = mne_pkg::CNT_W'(mne_pkg::N_IN);
  localparam logic [mne_pkg::CNT_W-1:0] L1_LAST = mne_pkg::CNT_W'(mne_pkg::N_LANE);

  logic [3:0]                state;
  logic [3:0]                state_next;
  logic [mne_pkg::CNT_W-1:0] cnt;
  logic [mne_pkg::CNT_W-1:0] cnt_next;
  logic [mne_pkg::CNT_W-1:0] nb_count;
  logic signed [mne_pkg::DATA_W-1:0] xs [mne_pkg::N_IN];
  logic                      acc_item;

  assign item_in.ready = (state == S_IDLE);
  assign acc_item      = item_in.valid && item_in.ready;

  always_ff @(posedge clk) begin
    if (acc_item && item_in.func == mne_pkg::FUNC_NEIGHBOR) begin
      xs[0] <= item_in.pos_x;
      xs[1] <= item_in.pos_y;
      xs[2] <= item_in.pos_z;
      xs[3] <= item_in.vel_x;
      xs[4] <= item_in.vel_y;
      xs[5] <= item_in.vel_z;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    out_load   = 1'b0;
    ctl        = '0;
    ctl.wr_en  = acc_item && item_in.func == mne_pkg::FUNC_COEF;
    ctl.wr_row = item_in.coef_addr[6:3];
    ctl.wr_lane = item_in.coef_addr[2:0];
    ctl.wr_data = item_in.coef_value;
    case (state)
      S_IDLE: begin
        if (acc_item && item_in.func == mne_pkg::FUNC_NEIGHBOR) begin
          state_next = S_L0;
          cnt_next   = '0;
        end
      end
      S_L0: begin
        // Input k uses row k; the step after the last input adds the bias.
        ctl.mac   = 1'b1;
        ctl.row   = cnt[mne_pkg::ROW_W-1:0];
        ctl.bcast = (cnt == L0_LAST) ? mne_pkg::BIAS_GAIN : xs[cnt[2:0]];
        if (cnt == L0_LAST) begin
          state_next = S_D0;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_D0: begin
        cnt_next = cnt + 1'b1;
        if (cnt[0]) begin
          state_next = S_HL;
        end
      end
      S_HL: begin
        ctl.hload  = 1'b1;
        state_next = S_L1;
        cnt_next   = '0;
      end
      S_L1: begin
        ctl.mac     = 1'b1;
        ctl.dst_sum = 1'b1;
        if (cnt == L1_LAST) begin
          ctl.row    = mne_pkg::ROW_B1;
          ctl.bcast  = mne_pkg::BIAS_GAIN;
          state_next = S_D1;
          cnt_next   = '0;
        end else begin
          ctl.rot       = 1'b1;
          ctl.step      = cnt[2:0];
          ctl.use_chain = 1'b1;
          ctl.shift     = 1'b1;
          cnt_next      = cnt + 1'b1;
        end
      end
      S_D1: begin
        cnt_next = cnt + 1'b1;
        if (cnt[0]) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (nb_count == NB_LAST) begin
          ctl.div_start = 1'b1;
          state_next    = S_DIV;
          cnt_next      = '0;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        // The reciprocal multiply result is registered in this state.
        ctl.div_step = 1'b1;
        state_next   = S_FIN;
      end
      S_FIN: begin
        if (!out_busy) begin
          out_load   = 1'b1;
          ctl.clr    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      nb_count <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == S_CHK) begin
        nb_count <= (nb_count == NB_LAST) ? '0 : nb_count + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/neighbor_mean_embedding_mlp_unit.sv
// Coefficient item: written on accept, next item accepted in the next cycle.
// Neighbor item: no new item is accepted until it has passed through both
// layers; the item that completes a group of NEIGHBORS also waits for the mean
// scaling and output load, and for the output register to be free.
// Synchronous reset clears the sequencer state, the table valid bits, the
// sums, the count and the output valid; nothing else needs clearing.
`default_nettype none
module neighbor_mean_embedding_mlp_unit (
  input  wire logic clk,
  input  wire logic rst,
  mne_in_if.sink    item_in,
  mne_out_if.source mean_out
);

  mne_pkg::ctl_t ctl;
  logic          out_load;
  logic          out_busy;
  logic signed [mne_pkg::DATA_W-1:0] h_ring [mne_pkg::N_LANE];
  logic signed [mne_pkg::DATA_W-1:0] means  [mne_pkg::N_LANE];

  // The sequencer owns the input handshake and issues one control word a
  // cycle to every lane.
  mne_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .item_in  (item_in),
    .out_busy (out_busy),
    .ctl      (ctl),
    .out_load (out_load)
  );

  // Eight lanes form a ring. During the second layer each lane hands its
  // hidden value to the lane below, so lane r sees hidden value (r + j) mod 8
  // on step j and reads the matching second-layer weight row.
  for (genvar r = 0; r < mne_pkg::N_LANE; r++) begin : g_lane
    mne_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .lane_id (mne_pkg::LANE_W'(r)),
      .ctl     (ctl),
      .h_in    (h_ring[(r + 1) % mne_pkg::N_LANE]),
      .h_out   (h_ring[r]),
      .mean    (means[r])
    );
  end

  // The output register holds a finished mean while the next items are
  // worked on; a new mean waits in the lanes until this register is free.
  assign out_busy = mean_out.valid && !mean_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_out.valid <= 1'b0;
    end else if (out_load) begin
      mean_out.valid <= 1'b1;
    end else if (mean_out.ready) begin
      mean_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_out.mean_0 <= means[0];
      mean_out.mean_1 <= means[1];
      mean_out.mean_2 <= means[2];
      mean_out.mean_3 <= means[3];
      mean_out.mean_4 <= means[4];
      mean_out.mean_5 <= means[5];
      mean_out.mean_6 <= means[6];
      mean_out.mean_7 <= means[7];
    end
  end

endmodule
`default_nettype wire
